### sv/jhd_pkg.sv
package jhd_pkg;

   localparam int BLOCK_COEFFS = 64;
   localparam int MAX_CODE_LEN = 16;
   localparam int POS_W        = 6;
   localparam int COUNT_W      = 7;

   localparam logic [7:0]  ZRL_SYMBOL = 8'd240;
   localparam logic [7:0]  EOB_SYMBOL = 8'd0;
   localparam logic [6:0]  ZRL_LENGTH = 7'd16;
   localparam logic [16:0] NO_CODE    = 17'h1ffff;

   typedef enum logic [2:0] {
      FUNC_DC_COUNT  = 3'd0,
      FUNC_AC_COUNT  = 3'd1,
      FUNC_DC_SYMBOL = 3'd2,
      FUNC_AC_SYMBOL = 3'd3,
      FUNC_DATA_BIT  = 3'd4
   } func_type;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_NO_CODE = 2'd1,
      STATUS_OVERRUN = 2'd2
   } status_type;

   typedef enum logic {
      FE_RUN,
      FE_LOOKUP
   } fe_state_type;

   // one command: count zeros from pos, then optionally one coefficient
   typedef struct packed {
      logic [POS_W-1:0]   pos;
      logic [COUNT_W-1:0] count;
      logic               has_coef;
      logic [15:0]        coef;
      status_type         status;
   } cmd_type;

   function automatic cmd_type make_cmd(input logic [POS_W-1:0] pos,
                                        input logic [COUNT_W-1:0] count,
                                        input logic has_coef,
                                        input logic [15:0] coef,
                                        input status_type status);
      cmd_type c;
      c.pos      = pos;
      c.count    = count;
      c.has_coef = has_coef;
      c.coef     = coef;
      c.status   = status;
      return c;
   endfunction

endpackage

### sv/jhd_front.sv
module jhd_front import jhd_pkg::*; #(
   parameter int AC_SYMBOL_DEPTH = 256,
   parameter int DC_SYMBOL_DEPTH = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [2:0] req_func,
   input  logic [7:0] req_load_index,
   input  logic [7:0] req_load_value,
   input  logic       req_code_bit,
   input  logic       q_full,
   output logic       q_push,
   output cmd_type    q_cmd
);

   localparam int AC_AW = $clog2(AC_SYMBOL_DEPTH);
   localparam int DC_AW = $clog2(DC_SYMBOL_DEPTH);

   fe_state_type state_ff, state_in;
   logic [16:0] load_code_run_ff, load_code_run_in;
   logic [8:0]  load_offset_run_ff, load_offset_run_in;
   logic [15:0] code_accum_ff, code_accum_in;
   logic [3:0]  code_length_ff, code_length_in;
   logic [5:0]  block_position_ff, block_position_in;
   logic [3:0]  extra_remaining_ff, extra_remaining_in;
   logic [15:0] extra_value_ff, extra_value_in;
   logic [3:0]  pending_run_ff, pending_run_in;
   logic        reading_extra_ff, reading_extra_in;

   logic [16:0] max_code_ff [2*MAX_CODE_LEN];
   logic [15:0] min_code_ff [2*MAX_CODE_LEN];
   logic [8:0]  value_offset_ff [2*MAX_CODE_LEN];
   logic [7:0]  dc_mem [DC_SYMBOL_DEPTH];
   logic [7:0]  ac_mem [AC_SYMBOL_DEPTH];

   logic [7:0]  sym_rd_ff;
   logic        range_ok_ff;

   logic        accept;
   logic        match;
   logic        max_we, mo_we, dc_we, ac_we;
   logic [4:0]  tbl_addr;
   logic [16:0] max_wd;
   logic [15:0] min_wd;
   logic [8:0]  off_wd;
   logic [15:0] sidx;
   logic        sidx_ac_ok, sidx_dc_ok;

   // per-cycle temporaries of the decode path
   logic [16:0] run_base;
   logic [8:0]  off_base;
   logic [15:0] acc_n;
   logic [4:0]  dec_addr;
   logic [16:0] mx;
   logic [15:0] ev_n;
   logic [15:0] coef_v;
   logic [7:0]  sym;
   logic [3:0]  sym_run, sym_cat;
   logic [6:0]  p_ext;

   assign accept   = req_push && !req_full;
   assign req_full = !(state_ff == FE_RUN && !q_full);

   assign acc_n    = {code_accum_ff[14:0], req_code_bit};
   assign dec_addr = {block_position_ff != 6'd0, code_length_ff};
   assign mx       = max_code_ff[dec_addr];
   assign sidx     = 16'(16'(value_offset_ff[dec_addr]) + acc_n - min_code_ff[dec_addr]);
   assign sidx_ac_ok = 32'(sidx) < AC_SYMBOL_DEPTH;
   assign sidx_dc_ok = 32'(sidx) < DC_SYMBOL_DEPTH;
   assign match    = accept && req_func == FUNC_DATA_BIT && !reading_extra_ff
                     && !mx[16] && !({1'b0, acc_n} > mx);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FE_RUN:    if (match) state_in = FE_LOOKUP;
         FE_LOOKUP: state_in = FE_RUN;
         default:   state_in = FE_RUN;
      endcase
   end

   // datapath and outputs
   always_comb begin
      load_code_run_in   = load_code_run_ff;
      load_offset_run_in = load_offset_run_ff;
      code_accum_in      = code_accum_ff;
      code_length_in     = code_length_ff;
      block_position_in  = block_position_ff;
      extra_remaining_in = extra_remaining_ff;
      extra_value_in     = extra_value_ff;
      pending_run_in     = pending_run_ff;
      reading_extra_in   = reading_extra_ff;
      q_push   = 1'b0;
      q_cmd    = make_cmd('0, '0, 1'b0, '0, STATUS_OK);
      max_we   = 1'b0;
      mo_we    = 1'b0;
      dc_we    = 1'b0;
      ac_we    = 1'b0;
      tbl_addr = {req_func[0], req_load_index[3:0]};
      max_wd   = NO_CODE;
      min_wd   = '0;
      off_wd   = '0;
      run_base = '0;
      off_base = '0;
      ev_n     = '0;
      coef_v   = '0;
      sym      = range_ok_ff ? sym_rd_ff : 8'd0;
      sym_run  = sym[7:4];
      sym_cat  = sym[3:0];
      p_ext    = {1'b0, block_position_ff};

      if (state_ff == FE_RUN && accept) begin
         unique case (req_func)
            FUNC_DC_COUNT, FUNC_AC_COUNT: begin
               if (req_load_index[7:4] == 4'd0) begin
                  run_base = (req_load_index[3:0] == 4'd0) ? 17'd0 : load_code_run_ff;
                  off_base = (req_load_index[3:0] == 4'd0) ? 9'd0 : load_offset_run_ff;
                  max_we   = 1'b1;
                  if (req_load_value != 8'd0) begin
                     mo_we  = 1'b1;
                     min_wd = run_base[15:0];
                     max_wd = 17'(run_base + 17'(req_load_value) - 17'd1);
                     off_wd = off_base;
                     load_code_run_in   = 17'((run_base + 17'(req_load_value)) << 1);
                     load_offset_run_in = 9'(off_base + 9'(req_load_value));
                  end else begin
                     load_code_run_in   = 17'(run_base << 1);
                     load_offset_run_in = off_base;
                  end
               end
            end
            FUNC_DC_SYMBOL: dc_we = 32'(req_load_index) < DC_SYMBOL_DEPTH;
            FUNC_AC_SYMBOL: ac_we = 32'(req_load_index) < AC_SYMBOL_DEPTH;
            FUNC_DATA_BIT: begin
               if (reading_extra_ff) begin
                  if (extra_value_ff == 16'd0)
                     ev_n = req_code_bit ? 16'h0001 : 16'hfffe;
                  else
                     ev_n = {extra_value_ff[14:0], req_code_bit};
                  extra_value_in     = ev_n;
                  extra_remaining_in = 4'(extra_remaining_ff - 4'd1);
                  if (extra_remaining_ff == 4'd1) begin
                     // negative values carry a set top bit, add one
                     coef_v = ev_n[15] ? 16'(ev_n + 16'd1) : ev_n;
                     q_push = 1'b1;
                     q_cmd  = make_cmd(block_position_ff, 7'(pending_run_ff), 1'b1,
                                       coef_v, STATUS_OK);
                     block_position_in  = 6'(block_position_ff + 6'(pending_run_ff) + 6'd1);
                     reading_extra_in   = 1'b0;
                     extra_remaining_in = '0;
                     extra_value_in     = '0;
                     pending_run_in     = '0;
                  end
               end else if (match) begin
                  code_accum_in  = '0;
                  code_length_in = '0;
               end else if (code_length_ff == 4'(MAX_CODE_LEN - 1)) begin
                  q_push = 1'b1;
                  q_cmd  = make_cmd(block_position_ff, '0, 1'b1, '0, STATUS_NO_CODE);
                  code_accum_in     = '0;
                  code_length_in    = '0;
                  block_position_in = '0;
               end else begin
                  code_accum_in  = acc_n;
                  code_length_in = 4'(code_length_ff + 4'd1);
               end
            end
            default: ;
         endcase
      end else if (state_ff == FE_LOOKUP) begin
         if (block_position_ff == 6'd0) begin
            if (sym_cat == 4'd0) begin
               q_push = 1'b1;
               q_cmd  = make_cmd('0, '0, 1'b1, '0, STATUS_OK);
               block_position_in = 6'd1;
            end else begin
               reading_extra_in   = 1'b1;
               extra_remaining_in = sym_cat;
               extra_value_in     = '0;
               pending_run_in     = '0;
            end
         end else if (sym == ZRL_SYMBOL) begin
            q_push = 1'b1;
            if (p_ext + ZRL_LENGTH > 7'(BLOCK_COEFFS)) begin
               q_cmd = make_cmd(block_position_ff, '0, 1'b1, '0, STATUS_OVERRUN);
               block_position_in = '0;
            end else begin
               q_cmd = make_cmd(block_position_ff, ZRL_LENGTH, 1'b0, '0, STATUS_OK);
               block_position_in = 6'(p_ext + ZRL_LENGTH);
            end
         end else if (sym == EOB_SYMBOL) begin
            q_push = 1'b1;
            q_cmd  = make_cmd(block_position_ff, 7'(7'(BLOCK_COEFFS) - p_ext), 1'b0, '0,
                              STATUS_OK);
            block_position_in = '0;
         end else if (p_ext + 7'(sym_run) > 7'(BLOCK_COEFFS - 1)) begin
            q_push = 1'b1;
            q_cmd  = make_cmd(block_position_ff, '0, 1'b1, '0, STATUS_OVERRUN);
            block_position_in = '0;
         end else if (sym_cat == 4'd0) begin
            q_push = 1'b1;
            q_cmd  = make_cmd(block_position_ff, 7'(7'(sym_run) + 7'd1), 1'b0, '0,
                              STATUS_OK);
            block_position_in = 6'(block_position_ff + 6'(sym_run) + 6'd1);
         end else begin
            reading_extra_in   = 1'b1;
            extra_remaining_in = sym_cat;
            extra_value_in     = '0;
            pending_run_in     = sym_run;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff           <= FE_RUN;
         load_code_run_ff   <= '0;
         load_offset_run_ff <= '0;
         code_accum_ff      <= '0;
         code_length_ff     <= '0;
         block_position_ff  <= '0;
         extra_remaining_ff <= '0;
         extra_value_ff     <= '0;
         pending_run_ff     <= '0;
         reading_extra_ff   <= 1'b0;
         for (int i = 0; i < 2*MAX_CODE_LEN; i++) max_code_ff[i] <= NO_CODE;
      end else begin
         state_ff           <= state_in;
         load_code_run_ff   <= load_code_run_in;
         load_offset_run_ff <= load_offset_run_in;
         code_accum_ff      <= code_accum_in;
         code_length_ff     <= code_length_in;
         block_position_ff  <= block_position_in;
         extra_remaining_ff <= extra_remaining_in;
         extra_value_ff     <= extra_value_in;
         pending_run_ff     <= pending_run_in;
         reading_extra_ff   <= reading_extra_in;
         if (max_we) max_code_ff[tbl_addr] <= max_wd;
      end
   end

   always_ff @(posedge clock) begin
      if (mo_we) begin
         min_code_ff[tbl_addr]     <= min_wd;
         value_offset_ff[tbl_addr] <= off_wd;
      end
   end

   // symbol memories: one write, one registered read
   always_ff @(posedge clock) begin
      if (dc_we) dc_mem[req_load_index[DC_AW-1:0]] <= req_load_value;
      if (match && block_position_ff == 6'd0 && sidx_dc_ok)
         sym_rd_ff <= dc_mem[sidx[DC_AW-1:0]];
      else if (match && block_position_ff != 6'd0 && sidx_ac_ok)
         sym_rd_ff <= ac_mem[sidx[AC_AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (ac_we) ac_mem[req_load_index[AC_AW-1:0]] <= req_load_value;
   end

   always_ff @(posedge clock) begin
      if (reset)
         range_ok_ff <= 1'b0;
      else if (match)
         range_ok_ff <= (block_position_ff == 6'd0) ? sidx_dc_ok : sidx_ac_ok;
   end

endmodule

### sv/jhd_cmd_queue.sv
module jhd_cmd_queue import jhd_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output cmd_type head,
   output logic    empty
);

   cmd_type    slot_ff [2];
   logic       wptr_ff, wptr_in;
   logic       rptr_ff, rptr_in;
   logic [1:0] count_ff, count_in;

   assign full  = count_ff == 2'd2;
   assign empty = count_ff == 2'd0;
   assign head  = slot_ff[rptr_ff];

   always_comb begin
      wptr_in  = wptr_ff ^ push;
      rptr_in  = rptr_ff ^ pop;
      count_in = 2'(count_ff + 2'(push) - 2'(pop));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= 1'b0;
         rptr_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wptr_ff] <= push_cmd;
   end

endmodule

### sv/jhd_back.sv
module jhd_back import jhd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     q_head,
   input  logic        q_empty,
   output logic        q_pop,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [15:0] rsp_coefficient,
   output logic [5:0]  rsp_position,
   output logic        rsp_last_in_block,
   output logic [1:0]  rsp_status
);

   logic        busy_ff, busy_in;
   cmd_type     cur_ff, cur_in;
   logic        ov_ff, ov_in;
   logic [15:0] ocoef_ff, ocoef_in;
   logic [5:0]  opos_ff, opos_in;
   logic        olast_ff, olast_in;
   logic [1:0]  ostat_ff, ostat_in;
   logic        can_emit;

   assign can_emit = !ov_ff || rsp_pop;

   always_comb begin
      busy_in  = busy_ff;
      cur_in   = cur_ff;
      ov_in    = ov_ff && !rsp_pop;
      ocoef_in = ocoef_ff;
      opos_in  = opos_ff;
      olast_in = olast_ff;
      ostat_in = ostat_ff;
      q_pop    = 1'b0;
      if (!busy_ff) begin
         if (!q_empty) begin
            q_pop   = 1'b1;
            cur_in  = q_head;
            busy_in = 1'b1;
         end
      end else if (can_emit) begin
         ov_in = 1'b1;
         if (cur_ff.count != '0) begin
            // zero run
            ocoef_in     = '0;
            opos_in      = cur_ff.pos;
            olast_in     = cur_ff.pos == 6'(BLOCK_COEFFS - 1);
            ostat_in     = STATUS_OK;
            cur_in.pos   = 6'(cur_ff.pos + 6'd1);
            cur_in.count = 7'(cur_ff.count - 7'd1);
            if (cur_ff.count == 7'd1 && !cur_ff.has_coef) busy_in = 1'b0;
         end else begin
            ocoef_in = cur_ff.coef;
            opos_in  = cur_ff.pos;
            olast_in = cur_ff.pos == 6'(BLOCK_COEFFS - 1) || cur_ff.status != STATUS_OK;
            ostat_in = cur_ff.status;
            busy_in  = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         ov_ff   <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         ov_ff   <= ov_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff   <= cur_in;
      ocoef_ff <= ocoef_in;
      opos_ff  <= opos_in;
      olast_ff <= olast_in;
      ostat_ff <= ostat_in;
   end

   assign rsp_empty         = !ov_ff;
   assign rsp_coefficient   = ocoef_ff;
   assign rsp_position      = opos_ff;
   assign rsp_last_in_block = olast_ff;
   assign rsp_status        = ostat_ff;

endmodule

### sv/jpeg_huffman_block_decoder.sv
// baseline jpeg huffman block decoder, one compressed bit per input transfer. count loads
// (ascending code length, length one restarts the table) and symbol loads fill the dc and ac
// decode tables; data bits then produce the block's coefficients in zigzag order, each with
// its position, the one at position 63 and every error result flagged as last. a bit that
// completes a code moves the front end into a lookup state that uses the registered read of
// the symbol memory and takes no transfer. the back end takes a command from the queue in a
// step of its own and then emits its results one at a time, so a zero run or end of block
// holds the back end while the front end keeps taking bits until its two-entry command
// queue fills.
module jpeg_huffman_block_decoder import jhd_pkg::*; #(
   parameter int AC_SYMBOL_DEPTH = 256,
   parameter int DC_SYMBOL_DEPTH = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  logic [2:0]         req_func,
   input  logic [7:0]         req_load_index,
   input  logic [7:0]         req_load_value,
   input  logic               req_code_bit,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic signed [15:0] rsp_coefficient,
   output logic [5:0]         rsp_position,
   output logic               rsp_last_in_block,
   output logic [1:0]         rsp_status
);

   // commands from the decoder front end to the result sequencer
   logic    q_push, q_full, q_pop, q_empty;
   cmd_type q_cmd, q_head;
   logic [15:0] coef_bits;

   // front end: table loads, bit matching, symbol lookup, run classification
   jhd_front #(
      .AC_SYMBOL_DEPTH(AC_SYMBOL_DEPTH),
      .DC_SYMBOL_DEPTH(DC_SYMBOL_DEPTH)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_func       (req_func),
      .req_load_index (req_load_index),
      .req_load_value (req_load_value),
      .req_code_bit   (req_code_bit),
      .q_full         (q_full),
      .q_push         (q_push),
      .q_cmd          (q_cmd)
   );

   jhd_cmd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (q_cmd),
      .full     (q_full),
      .pop      (q_pop),
      .head     (q_head),
      .empty    (q_empty)
   );

   // back end: expands each command into result transfers through an output register
   jhd_back u_back (
      .clock             (clock),
      .reset             (reset),
      .q_head            (q_head),
      .q_empty           (q_empty),
      .q_pop             (q_pop),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_coefficient   (coef_bits),
      .rsp_position      (rsp_position),
      .rsp_last_in_block (rsp_last_in_block),
      .rsp_status        (rsp_status)
   );

   assign rsp_coefficient = signed'(coef_bits);

   // the queue never takes a command it has no room for
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("command pushed into full queue");

   // an error result always closes the block
   a_error_last: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_status != STATUS_OK) |-> rsp_last_in_block)
      else $error("error result without last flag");

   // an error result carries a zero coefficient
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_status != STATUS_OK) |-> rsp_coefficient == 16'sd0)
      else $error("error result with nonzero coefficient");

endmodule

### bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
   import jhd_pkg::*;

   // reserved func codes that the block must ignore
   localparam logic [2:0] FUNC_SPARE_LO = 3'd5;
   localparam logic [2:0] FUNC_SPARE_HI = 3'd7;
   localparam int         ITEM_TARGET   = 330;

   typedef struct {
      logic [15:0] coef;
      logic [5:0]  pos;
      logic        last;
      status_type  status;
   } coef_type;

   typedef struct {
      logic [2:0] func;
      logic [7:0] idx;
      logic [7:0] val;
      logic       code_bit;
      bit         typed;
      coef_type   typed_result;
   } stim_row_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_push = 1'b0;
   logic               req_full;
   logic [2:0]         req_func = FUNC_DATA_BIT;
   logic [7:0]         req_load_index = '0;
   logic [7:0]         req_load_value = '0;
   logic               req_code_bit = 1'b0;
   logic               rsp_empty;
   logic               rsp_pop = 1'b0;
   logic signed [15:0] rsp_coefficient;
   logic [5:0]         rsp_position;
   logic               rsp_last_in_block;
   logic [1:0]         rsp_status;

   jpeg_huffman_block_decoder i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_func          (req_func),
      .req_load_index    (req_load_index),
      .req_load_value    (req_load_value),
      .req_code_bit      (req_code_bit),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_coefficient   (rsp_coefficient),
      .rsp_position      (rsp_position),
      .rsp_last_in_block (rsp_last_in_block),
      .rsp_status        (rsp_status)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // run limit, far beyond the slowest legal run
   initial begin
      #20ms;
      $display("** jpeg_huffman_block_decoder: FAILED **");
      $finish;
   end

   // ---------------------------------------------------------------
   // decoder predictor: own copy of tables and block state
   // ---------------------------------------------------------------
   bit [15:0] tbl_min[32];
   bit [16:0] tbl_max[32];
   bit [8:0]  tbl_offset[32];
   bit [7:0]  dc_values[16];
   bit [7:0]  ac_values[256];
   bit [16:0] build_code;
   bit [8:0]  build_offset;
   bit [15:0] bit_accum;
   bit [3:0]  bit_count;
   bit [5:0]  blk_pos;
   bit [3:0]  extra_left;
   bit [15:0] extra_bits;
   bit [3:0]  zero_run;
   bit        in_extra;

   coef_type step_out[$];     // results caused by the current transfer
   coef_type coef_expect[$];  // results still owed by the block

   int errors      = 0;
   int items_sent  = 0;
   int checked     = 0;
   int no_code_cnt = 0;
   int overrun_cnt = 0;
   int blocks_sent = 0;
   bit burst_in    = 0;
   bit burst_out   = 0;

   initial begin
      for (int i = 0; i < 32; i++) tbl_max[i] = '1;
   end

   function automatic void add_coef(int coef, int pos, bit last, status_type st);
      coef_type c;
      c.coef   = coef[15:0];
      c.pos    = pos[5:0];
      c.last   = last;
      c.status = st;
      step_out.push_back(c);
   endfunction

   function automatic void add_zeros(int pos, int count);
      for (int i = 0; i < count; i++)
         add_coef(0, pos + i, (pos + i) == BLOCK_COEFFS - 1, STATUS_OK);
   endfunction

   function automatic void clear_block();
      bit_accum  = '0;
      bit_count  = '0;
      blk_pos    = '0;
      extra_left = '0;
      extra_bits = '0;
      zero_run   = '0;
      in_extra   = 1'b0;
   endfunction

   function automatic void block_error(status_type st);
      add_coef(0, blk_pos, 1'b1, st);
      clear_block();
   endfunction

   function automatic void load_length(int base, int len, int count);
      if (len == 0) begin
         build_code   = '0;
         build_offset = '0;
      end
      if (count != 0) begin
         tbl_min[base+len]    = build_code[15:0];
         tbl_max[base+len]    = build_code + 17'(count) - 17'd1;
         tbl_offset[base+len] = build_offset;
         build_code           = build_code + 17'(count);
         build_offset         = build_offset + 9'(count);
      end else begin
         tbl_max[base+len] = NO_CODE;
      end
      build_code = build_code << 1;
   endfunction

   function automatic void on_symbol(bit [7:0] sym);
      int p   = blk_pos;
      int run = sym[7:4];
      int cat = sym[3:0];
      if (p == 0) begin
         if (cat == 0) begin
            blk_pos = 6'd1;
            add_coef(0, 0, 1'b0, STATUS_OK);
         end else begin
            in_extra = 1'b1; extra_left = 4'(cat); extra_bits = '0; zero_run = '0;
         end
      end else if (sym == ZRL_SYMBOL) begin
         if (p + ZRL_LENGTH > BLOCK_COEFFS) block_error(STATUS_OVERRUN);
         else begin
            add_zeros(p, ZRL_LENGTH);
            blk_pos = 6'(p + ZRL_LENGTH);
         end
      end else if (sym == EOB_SYMBOL) begin
         add_zeros(p, BLOCK_COEFFS - p);
         blk_pos = '0;
      end else if (p + run > BLOCK_COEFFS - 1) begin
         block_error(STATUS_OVERRUN);
      end else if (cat == 0) begin
         add_zeros(p, run + 1);
         blk_pos = 6'(p + run + 1);
      end else begin
         in_extra = 1'b1; extra_left = 4'(cat); extra_bits = '0; zero_run = 4'(run);
      end
   endfunction

   // one transfer through the predictor; results land in step_out
   function automatic void decode_step(logic [2:0] func, logic [7:0] idx,
                                       logic [7:0] val, logic code_bit);
      int        base, len, p;
      bit [16:0] mx;
      bit [15:0] v, sidx;
      bit [7:0]  sym;
      step_out.delete();
      case (func)
         FUNC_DC_COUNT, FUNC_AC_COUNT: begin
            if (idx < MAX_CODE_LEN)
               load_length(func == FUNC_AC_COUNT ? MAX_CODE_LEN : 0, idx, val);
         end
         FUNC_DC_SYMBOL: if (idx < 16) dc_values[idx[3:0]] = val;
         FUNC_AC_SYMBOL: ac_values[idx] = val;
         FUNC_DATA_BIT: begin
            if (in_extra) begin
               if (extra_bits == 0) extra_bits = code_bit ? 16'h0001 : 16'hfffe;
               else extra_bits = {extra_bits[14:0], code_bit};
               extra_left = extra_left - 4'd1;
               if (extra_left == 0) begin
                  v = extra_bits;
                  if (v[15]) v = v + 16'd1;   // negative value, JPEG sign rule
                  p = blk_pos;
                  add_zeros(p, zero_run);
                  add_coef(v, p + zero_run, (p + zero_run) == BLOCK_COEFFS - 1, STATUS_OK);
                  blk_pos    = 6'(p + zero_run + 1);
                  in_extra   = 1'b0;
                  extra_left = '0;
                  extra_bits = '0;
                  zero_run   = '0;
               end
            end else begin
               bit_accum = {bit_accum[14:0], code_bit};
               base = (blk_pos == 0) ? 0 : MAX_CODE_LEN;
               len  = bit_count;
               mx   = tbl_max[base+len];
               if (mx[16] || {1'b0, bit_accum} > mx) begin
                  if (len >= MAX_CODE_LEN - 1) block_error(STATUS_NO_CODE);
                  else bit_count = 4'(len + 1);
               end else begin
                  sidx = 16'(tbl_offset[base+len] + bit_accum - tbl_min[base+len]);
                  bit_accum = '0;
                  bit_count = '0;
                  if (base == 0) sym = (sidx < 16) ? dc_values[sidx[3:0]] : 8'd0;
                  else sym = (sidx < 256) ? ac_values[sidx[7:0]] : 8'd0;
                  on_symbol(sym);
               end
            end
         end
         default: ;
      endcase
   endfunction

   // ---------------------------------------------------------------
   // input side
   // ---------------------------------------------------------------
   // one transfer; the predictor runs on acceptance
   task automatic send_item(logic [2:0] func, logic [7:0] idx, logic [7:0] val,
                            logic code_bit, bit typed = 0,
                            coef_type typed_result = '{coef: 16'd0, pos: 6'd0, last: 1'b0,
                                                       status: STATUS_OK});
      int gap = burst_in ? 0 : $urandom_range(0, 10);
      repeat (gap) begin
         @(negedge clock);
         req_push <= 1'b0;
      end
      @(negedge clock);
      req_push       <= 1'b1;
      req_func       <= func;
      req_load_index <= idx;
      req_load_value <= val;
      req_code_bit   <= code_bit;
      do @(posedge clock); while (req_full);
      decode_step(func, idx, val, code_bit);
      if (typed) coef_expect.push_back(typed_result);
      else foreach (step_out[i]) coef_expect.push_back(step_out[i]);
      items_sent++;
      if (items_sent % 40 == 0) burst_in = ($urandom_range(0, 2) == 0);
   endtask

   // encoder side of the current tables
   int        dc_len[16], ac_len[40];
   bit [15:0] dc_code[16], ac_code[40];
   bit [7:0]  dc_sym[16], ac_sym[40];
   int        dc_total, ac_total;

   task automatic load_table(bit is_ac);
      int code = 0, total = 0, cnt, lim, avail;
      int cap = is_ac ? 40 : 12;
      bit [7:0] s;
      for (int l = 1; l <= MAX_CODE_LEN; l++) begin
         avail = (1 << l) - code;
         cnt = 0;
         if (total < cap && $urandom_range(0, 2) != 0) begin
            lim = avail;
            if (lim > cap - total) lim = cap - total;
            if (lim > 8) lim = 8;
            cnt = $urandom_range(0, lim);
         end
         if (l == 3 && total == 0) cnt = 1;
         for (int k = 0; k < cnt; k++) begin
            if (is_ac) begin ac_len[total+k] = l; ac_code[total+k] = 16'(code + k); end
            else begin dc_len[total+k] = l; dc_code[total+k] = 16'(code + k); end
         end
         send_item(is_ac ? FUNC_AC_COUNT : FUNC_DC_COUNT, 8'(l - 1), 8'(cnt),
                   1'($urandom_range(0, 1)));
         code  = (code + cnt) << 1;
         total = total + cnt;
      end
      for (int k = 0; k < total; k++) begin
         if (is_ac) begin
            if (k == 0) s = EOB_SYMBOL;
            else if (k == 1) s = ZRL_SYMBOL;
            else if ($urandom_range(0, 5) == 0) s = 8'($urandom_range(0, 255));
            else s = {4'($urandom_range(0, 15)), 4'($urandom_range(0, 10))};
            ac_sym[k] = s;
         end else begin
            s = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
                                            : 8'($urandom_range(0, 11));
            dc_sym[k] = s;
         end
         send_item(is_ac ? FUNC_AC_SYMBOL : FUNC_DC_SYMBOL, 8'(k), s,
                   1'($urandom_range(0, 1)));
      end
      if (is_ac) ac_total = total;
      else dc_total = total;
   endtask

   task automatic send_code(int len, bit [15:0] code);
      for (int b = len - 1; b >= 0; b--) send_item(FUNC_DATA_BIT, 8'd0, 8'd0, code[b]);
   endtask

   task automatic send_extra(bit [3:0] cat);
      for (int b = 0; b < cat; b++)
         send_item(FUNC_DATA_BIT, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   1'($urandom_range(0, 1)));
   endtask

   // one well-formed block: dc symbol, then ac symbols until the block wraps
   task automatic send_block();
      int k;
      k = $urandom_range(0, dc_total - 1);
      send_code(dc_len[k], dc_code[k]);
      send_extra(dc_sym[k][3:0]);
      while (blk_pos != 0) begin
         k = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(0, ac_total - 1);
         send_code(ac_len[k], ac_code[k]);
         if (blk_pos != 0 && in_extra) send_extra(ac_sym[k][3:0]);
      end
      blocks_sent++;
   endtask

   // random bits, then more until the decoder is back between blocks or 200 more were sent
   task automatic send_noise();
      int n = 0;
      repeat ($urandom_range(4, 20))
         send_item(FUNC_DATA_BIT, 8'd0, 8'd0, 1'($urandom_range(0, 1)));
      while ((blk_pos != 0 || in_extra || bit_count != 0) && n < 200) begin
         send_item(FUNC_DATA_BIT, 8'd0, 8'd0, 1'($urandom_range(0, 1)));
         n++;
      end
   endtask

   stim_row_type directed[$];

   task automatic add_row(logic [2:0] f, logic [7:0] i, logic [7:0] v, logic b,
                          bit typed = 0,
                          coef_type r = '{coef: 16'd0, pos: 6'd0, last: 1'b0,
                                          status: STATUS_OK});
      stim_row_type row;
      row.func = f; row.idx = i; row.val = v; row.code_bit = b;
      row.typed = typed; row.typed_result = r;
      directed.push_back(row);
   endtask

   initial begin
      coef_type nc;
      int tables;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: ignored codes, field extremes, then a bitstream with no dc table
      add_row(FUNC_SPARE_HI, 8'hff, 8'hff, 1'b1);
      add_row(FUNC_SPARE_LO, 8'h00, 8'h00, 1'b0);
      add_row(FUNC_DC_COUNT, 8'd16, 8'hff, 1'b0);
      add_row(FUNC_AC_COUNT, 8'hff, 8'h00, 1'b1);
      add_row(FUNC_DC_SYMBOL, 8'd16, 8'hff, 1'b0);
      add_row(FUNC_AC_SYMBOL, 8'hff, 8'hff, 1'b1);
      add_row(FUNC_AC_COUNT, 8'h00, 8'hff, 1'b0);
      // after reset no dc code exists: sixteen bits end in a no-code error
      for (int i = 0; i < 15; i++) add_row(FUNC_DATA_BIT, 8'h00, 8'h00, i[0]);
      nc = '{coef: 16'd0, pos: 6'd0, last: 1'b1, status: STATUS_NO_CODE};
      add_row(FUNC_DATA_BIT, 8'hff, 8'hff, 1'b1, 1, nc);
      foreach (directed[i])
         send_item(directed[i].func, directed[i].idx, directed[i].val,
                   directed[i].code_bit, directed[i].typed, directed[i].typed_result);

      // random: table sets, each followed by blocks with some noise between
      while (items_sent < ITEM_TARGET) begin
         load_table(0);
         load_table(1);
         tables = 0;
         while (tables < 3 && items_sent < ITEM_TARGET) begin
            if ($urandom_range(0, 4) == 0) send_noise();
            else send_block();
            tables++;
         end
      end
      @(negedge clock);
      req_push <= 1'b0;

      while (coef_expect.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      $display("items %0d, blocks %0d, results checked %0d", items_sent, blocks_sent, checked);
      $display("error results: no-code %0d, overrun %0d", no_code_cnt, overrun_cnt);
      if (errors == 0 && coef_expect.size() == 0) begin
         $display("** jpeg_huffman_block_decoder: PASSED **");
      end else begin
         $display("** jpeg_huffman_block_decoder: FAILED **");
      end
      $finish;
   end

   // ---------------------------------------------------------------
   // result side
   // ---------------------------------------------------------------
   task automatic report(string what);
      errors++;
      $display("mismatch at %0t: %s", $realtime, what);
   endtask

   always begin : result_sink
      int       w;
      coef_type e;
      w = burst_out ? 0 : $urandom_range(0, 10);
      repeat (w) begin
         @(negedge clock);
         rsp_pop <= 1'b0;
      end
      @(negedge clock);
      rsp_pop <= 1'b1;
      do @(posedge clock); while (rsp_empty || reset);
      // transfer on this edge
      checked++;
      if (rsp_status == STATUS_NO_CODE) no_code_cnt++;
      if (rsp_status == STATUS_OVERRUN) overrun_cnt++;
      if (checked % 50 == 0) burst_out = ($urandom_range(0, 2) == 0);
      if (coef_expect.size() == 0) begin
         report($sformatf("unexpected result pos %0d", rsp_position));
      end else begin
         e = coef_expect.pop_front();
         if (rsp_coefficient !== e.coef || rsp_position !== e.pos ||
             rsp_last_in_block !== e.last || rsp_status !== e.status)
            report($sformatf("got coef %0d pos %0d last %0b st %0d, want %0d %0d %0b %0d",
                             rsp_coefficient, rsp_position, rsp_last_in_block, rsp_status,
                             $signed(e.coef), e.pos, e.last, e.status));
      end
   end

endmodule
